[rtl/core/evrs_pkg.sv]
// ----------------------------------------------------------------------------
// evrs_pkg
// Types and constants shared by the excluded value remap sampler.
// ----------------------------------------------------------------------------
package evrs_pkg;

  localparam int unsigned ValW   = 30;
  localparam int unsigned RangeW = 31;
  localparam int unsigned ModSteps = 31;
  localparam logic [RangeW-1:0] RangeCap = 31'h4000_0000;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_BUILD = 2'd2,
    ACT_PICK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTBUILT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    TK_ADD   = 3'd0,
    TK_CNT   = 3'd1,
    TK_RANK  = 3'd2,
    TK_PROBE = 3'd3,
    TK_LOOK  = 3'd4
  } tok_kind_e;

  typedef struct packed {
    logic              vld;
    tok_kind_e         kind;
    logic [RangeW-1:0] val;
    logic              hit;
  } tok_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ValW-1:0]   entry_value;
    logic [RangeW-1:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] result_value;
    logic [1:0]      status;
  } out_item_t;

endpackage

[rtl/core/evrs_cell.sv]
// ----------------------------------------------------------------------------
// evrs_cell
// One table slot: excluded key, remap target and build rank; updates the
// passing token and hands it to the next slot.
// ----------------------------------------------------------------------------
module evrs_cell import evrs_pkg::*; #(
  parameter int unsigned CW  = 7,
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tok_t            tok_i,
  input  logic [CW-1:0]   acc_i,
  input  logic [CW-1:0]   count_i,
  input  logic            tw_en_i,
  input  logic [CW-1:0]   tw_rank_i,
  input  logic [ValW-1:0] tw_val_i,
  output tok_t            tok_o,
  output logic [CW-1:0]   acc_o
);

  tok_t              tok_d, tok_q;
  logic [CW-1:0]     acc_d, acc_q;
  logic [ValW-1:0]   key_d, key_q;
  logic [ValW-1:0]   tgt_q;
  logic [CW-1:0]     rank_d, rank_q;
  logic              low_d, low_q;
  logic              live;
  logic [RangeW-1:0] key_x;

  assign live  = CW'(IDX) < count_i;
  assign key_x = {1'b0, key_q};

  always_comb begin
    tok_d  = tok_i;
    acc_d  = acc_i;
    key_d  = key_q;
    rank_d = rank_q;
    low_d  = low_q;
    if (tok_i.vld) begin
      case (tok_i.kind)
        TK_ADD: begin
          if (live && key_x == tok_i.val) tok_d.hit = 1'b1;
          if (CW'(IDX) == count_i && !tok_i.hit) key_d = tok_i.val[ValW-1:0];
        end
        TK_CNT: begin
          if (live && key_x < tok_i.val) acc_d = acc_i + 1'b1;
        end
        TK_RANK: begin
          low_d = live && key_x < tok_i.val;
          if (live && key_x < tok_i.val) begin
            rank_d = acc_i;
            acc_d  = acc_i + 1'b1;
          end
        end
        TK_PROBE: begin
          if (live && key_x == tok_i.val) tok_d.hit = 1'b1;
        end
        TK_LOOK: begin
          if (live && !tok_i.hit && key_x == tok_i.val) begin
            tok_d.val = {1'b0, tgt_q};
            tok_d.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      low_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      low_q <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    key_q  <= key_d;
    rank_q <= rank_d;
    if (tw_en_i && low_q && rank_q == tw_rank_i) tgt_q <= tw_val_i;
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

[rtl/core/evrs_mod.sv]
// ----------------------------------------------------------------------------
// evrs_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module evrs_mod import evrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RangeW-1:0] dividend_i,
  input  logic [RangeW-1:0] divisor_i,
  output logic              done_o,
  output logic [RangeW-1:0] rem_o
);

  localparam int unsigned SW = $clog2(ModSteps);

  logic              busy_d, busy_q;
  logic              done_d, done_q;
  logic [SW-1:0]     cnt_d, cnt_q;
  logic [RangeW-1:0] div_d, div_q;
  logic [RangeW-1:0] rem_d, rem_q;
  logic [RangeW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, div_q[RangeW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      div_d = {div_q[RangeW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) rem_d = RangeW'(trial - {1'b0, divisor_i});
      else rem_d = trial[RangeW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == SW'(ModSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/excluded_value_remap_sampler_top.sv]
// ----------------------------------------------------------------------------
// excluded_value_remap_sampler_top
// Draws from [0, range_size) avoiding a table of excluded values, which are
// remapped onto free values at the top of the range.
// ----------------------------------------------------------------------------
//  channel  signals                           direction
//  in       in_valid_i in_ready_o in_item_i   item in
//  out      out_valid_o out_ready_i out_item_o item out
//  cfg      cfg_valid_i cfg_ready_o cfg_data_i range_size write
//
//  One item at a time. A token walks the row of MAX_ENTRIES cells, one cell
//  per cycle. Clear or a rejected item goes straight to the output. Add walks
//  the row once. Build walks a count token, then a rank token and one probe
//  token per in-range excluded value. Pick: 31-step remainder, then the row walk.
//  A waiting result sits in the output register while the next item is taken.
//  No clearing pass after reset.
// ----------------------------------------------------------------------------
module excluded_value_remap_sampler_top import evrs_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [RangeW-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned OW = $clog2(MAX_ENTRIES + 2);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_WAIT  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e            state_d, state_q;
  logic [RangeW-1:0] range_d, range_q;
  logic [CW-1:0]     count_d, count_q;
  logic [RangeW-1:0] kept_d, kept_q;
  logic              built_d, built_q;
  action_e           act_d, act_q;
  tok_t              inj_d, inj_q;
  logic [RangeW-1:0] pval_d, pval_q;
  logic [CW-1:0]     inj_left_d, inj_left_q;
  logic [OW-1:0]     out_left_d, out_left_q;
  logic [CW-1:0]     free_d, free_q;
  logic [ValW-1:0]   res_d, res_q;
  logic [1:0]        stat_d, stat_q;
  logic              ov_d, ov_q;
  out_item_t         oi_d, oi_q;

  logic              mod_start, mod_done;
  logic [RangeW-1:0] mod_rem;
  logic              tw_en;
  logic [CW-1:0]     tw_rank;
  logic [ValW-1:0]   tw_val;
  tok_kind_e         want;

  tok_t              chain_tok [MAX_ENTRIES+1];
  logic [CW-1:0]     chain_acc [MAX_ENTRIES+1];
  tok_t              tail;

  assign chain_tok[0] = inj_q;
  assign chain_acc[0] = '0;
  assign tail         = chain_tok[MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    evrs_cell #(.CW(CW), .IDX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (chain_tok[g]),
      .acc_i     (chain_acc[g]),
      .count_i   (count_q),
      .tw_en_i   (tw_en),
      .tw_rank_i (tw_rank),
      .tw_val_i  (tw_val),
      .tok_o     (chain_tok[g+1]),
      .acc_o     (chain_acc[g+1])
    );
  end

  evrs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_item_i.random_draw),
    .divisor_i  (kept_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    case (act_q)
      ACT_ADD:   want = TK_ADD;
      ACT_BUILD: want = TK_CNT;
      default:   want = TK_LOOK;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    range_d    = range_q;
    count_d    = count_q;
    kept_d     = kept_q;
    built_d    = built_q;
    act_d      = act_q;
    inj_d      = '0;
    pval_d     = pval_q;
    inj_left_d = inj_left_q;
    out_left_d = out_left_q;
    free_d     = free_q;
    res_d      = res_q;
    stat_d     = stat_q;
    mod_start  = 1'b0;
    tw_en      = 1'b0;
    tw_rank    = free_q;
    tw_val     = tail.val[ValW-1:0];
    ov_d       = ov_q && !out_ready_i;
    oi_d       = oi_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = action_e'(in_item_i.action);
          res_d = '0;
          stat_d = ST_OK;
          case (action_e'(in_item_i.action))
            ACT_CLEAR: begin
              count_d = '0;
              kept_d  = '0;
              built_d = 1'b0;
              state_d = S_DONE;
            end
            ACT_ADD: begin
              if ({1'b0, in_item_i.entry_value} >= range_q) begin
                stat_d  = ST_IGNORED;
                state_d = S_DONE;
              end else begin
                inj_d   = '{vld: 1'b1, kind: TK_ADD,
                            val: {1'b0, in_item_i.entry_value}, hit: 1'b0};
                state_d = S_WAIT;
              end
            end
            ACT_BUILD: begin
              inj_d   = '{vld: 1'b1, kind: TK_CNT, val: range_q, hit: 1'b0};
              state_d = S_WAIT;
            end
            default: begin
              if (!built_q || kept_q == '0) begin
                stat_d  = ST_NOTBUILT;
                state_d = S_DONE;
              end else begin
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          inj_d   = '{vld: 1'b1, kind: TK_LOOK, val: mod_rem, hit: 1'b0};
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (tail.vld && tail.kind == want) begin
          case (act_q)
            ACT_ADD: begin
              state_d = S_DONE;
              if (!tail.hit) begin
                if (count_q >= CW'(MAX_ENTRIES)) begin
                  stat_d = ST_FULL;
                end else begin
                  count_d = CW'(count_q + 1'b1);
                  built_d = 1'b0;
                end
              end
            end
            ACT_BUILD: begin
              kept_d     = range_q - RangeW'(chain_acc[MAX_ENTRIES]);
              inj_d      = '{vld: 1'b1, kind: TK_RANK, val: kept_d, hit: 1'b0};
              pval_d     = range_q - 1'b1;
              inj_left_d = chain_acc[MAX_ENTRIES];
              out_left_d = OW'(chain_acc[MAX_ENTRIES]) + 1'b1;
              free_d     = '0;
              state_d    = S_PROBE;
            end
            default: begin
              res_d   = tail.val[ValW-1:0];
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (inj_left_q != '0) begin
          inj_d      = '{vld: 1'b1, kind: TK_PROBE, val: pval_q, hit: 1'b0};
          pval_d     = pval_q - 1'b1;
          inj_left_d = inj_left_q - 1'b1;
        end
        if (tail.vld && (tail.kind == TK_RANK || tail.kind == TK_PROBE)) begin
          out_left_d = out_left_q - 1'b1;
          if (tail.kind == TK_PROBE && !tail.hit) begin
            tw_en  = 1'b1;
            free_d = free_q + 1'b1;
          end
        end
        if (out_left_q == '0) begin
          built_d = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          oi_d    = '{result_value: res_q, status: stat_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i) begin
      range_d = (cfg_data_i > RangeCap) ? RangeCap : cfg_data_i;
      built_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      range_q    <= RangeW'(1);
      count_q    <= '0;
      kept_q     <= '0;
      built_q    <= 1'b0;
      act_q      <= ACT_CLEAR;
      inj_q      <= '0;
      inj_left_q <= '0;
      out_left_q <= '0;
      free_q     <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      range_q    <= range_d;
      count_q    <= count_d;
      kept_q     <= kept_d;
      built_q    <= built_d;
      act_q      <= act_d;
      inj_q      <= inj_d;
      inj_left_q <= inj_left_d;
      out_left_q <= out_left_d;
      free_q     <= free_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pval_q <= pval_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    oi_q   <= oi_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign out_item_o  = oi_q;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

  a_kept_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> kept_q <= range_q)
    else $error("kept size above range");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the excluded value remap sampler: a table of directed items and directed
// sequences, then random clear/add/build/pick sequences under several range sizes,
// each result compared in order against a behavioral predictor of the table and remap.
// ----------------------------------------------------------------------------
module testbench;
  import evrs_pkg::*;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned WatchLimit = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [RangeW-1:0] cfg_data;

  excluded_value_remap_sampler_top #(.MAX_ENTRIES(MaxEntries)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  typedef struct {
    action_e     act;
    logic [29:0] val;
    logic [30:0] draw;
    bit          fixed;
    out_item_t   res;
  } row_t;

  logic [RangeW-1:0] model_range;
  logic [ValW-1:0]   model_keys [MaxEntries];
  logic [ValW-1:0]   model_tgts [MaxEntries];
  int unsigned       model_count;
  logic [RangeW-1:0] model_kept;
  bit                model_built;

  out_item_t pending_results [$];
  int unsigned errors;
  int unsigned idle_cycles;
  bit          done_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit key_present(logic [31:0] v);
    for (int unsigned i = 0; i < model_count; i++) begin
      if (model_keys[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_sample(in_item_t it);
    out_item_t r;
    int unsigned n;
    logic [31:0] top;
    logic [31:0] idx;
    r.result_value = '0;
    r.status = ST_OK;
    case (action_e'(it.action))
      ACT_CLEAR: begin
        model_count = 0;
        model_kept = '0;
        model_built = 1'b0;
      end
      ACT_ADD: begin
        if ({2'b0, it.entry_value} >= model_range) r.status = ST_IGNORED;
        else if (key_present(it.entry_value)) r.status = ST_OK;
        else if (model_count >= MaxEntries) r.status = ST_FULL;
        else begin
          model_keys[model_count] = it.entry_value;
          model_tgts[model_count] = '0;
          model_count++;
          model_built = 1'b0;
        end
      end
      ACT_BUILD: begin
        n = 0;
        for (int unsigned i = 0; i < model_count; i++) begin
          if ({1'b0, model_keys[i]} < model_range) n++;
        end
        model_kept = model_range - n;
        top = model_range;
        for (int unsigned i = 0; i < model_count; i++) begin
          if ({1'b0, model_keys[i]} < model_kept) begin
            do top--; while (top > model_kept && key_present(top));
            model_tgts[i] = top[29:0];
          end
        end
        model_built = 1'b1;
      end
      default: begin
        if (!model_built || model_kept == 0) r.status = ST_NOTBUILT;
        else begin
          idx = it.random_draw % model_kept;
          r.result_value = idx[29:0];
          for (int unsigned i = 0; i < model_count; i++) begin
            if (model_keys[i] == idx) begin
              r.result_value = model_tgts[i];
              break;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_item(in_item_t it, bit fixed, out_item_t fixed_res);
    out_item_t p;
    repeat (gap_len() + 1) @(posedge clk);
    p = predict_sample(it);
    if (fixed && p != fixed_res) begin
      $display("%0t predictor table row: expected %h actual %h", $time, fixed_res, p);
      errors++;
    end
    pending_results.push_back(p);
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
  endtask

  task automatic write_range(logic [RangeW-1:0] v);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * MaxEntries + 16) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_range = (v > RangeCap) ? RangeCap : v;
    model_built = 1'b0;
  endtask

  task automatic send_op(action_e a, logic [29:0] v, logic [30:0] d);
    in_item_t it;
    it.action = a;
    it.entry_value = v;
    it.random_draw = d;
    send_item(it, 1'b0, '0);
  endtask

  task automatic random_phase(int unsigned items, logic [RangeW-1:0] rng);
    logic [29:0] v;
    int unsigned k;
    int unsigned sent;
    int unsigned n_pick;
    sent = 0;
    while (sent < items) begin
      send_op(ACT_CLEAR, 30'($urandom), 31'($urandom));
      k = $urandom_range(0, 5) == 0 ? $urandom_range(60, 70) : $urandom_range(0, 12);
      for (int unsigned i = 0; i < k; i++) begin
        case ($urandom_range(0, 9))
          0: v = 30'($urandom);
          1: v = 30'(rng - 1 - $urandom_range(0, 3));
          default: v = (rng > 1) ? 30'($urandom_range(0, 32'(rng) - 1)) : '0;
        endcase
        if ($urandom_range(0, 9) == 0 && rng <= 64) v = 30'($urandom_range(0, 63));
        send_op(ACT_ADD, v, 31'($urandom));
      end
      if ($urandom_range(0, 9) != 0) send_op(ACT_BUILD, 30'($urandom), 31'($urandom));
      n_pick = $urandom_range(2, 10);
      for (int unsigned i = 0; i < n_pick; i++) begin
        send_op(ACT_PICK, 30'($urandom), 31'($urandom));
      end
      if ($urandom_range(0, 7) == 0) send_op(action_e'($urandom_range(0, 3)),
                                             30'($urandom), 31'($urandom));
      sent += k + n_pick + 2;
    end
  endtask

  row_t rows [$];

  function automatic row_t mk(action_e a, logic [29:0] v, logic [30:0] d, bit f,
                              status_e s, logic [29:0] rv);
    row_t r;
    r.act = a; r.val = v; r.draw = d; r.fixed = f;
    r.res.status = s; r.res.result_value = rv;
    return r;
  endfunction

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    model_range = 1;
    model_count = 0;
    model_kept = '0;
    model_built = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(mk(ACT_PICK, '0, '1, 1, ST_NOTBUILT, '0));
    rows.push_back(mk(ACT_ADD, 30'd1, '0, 1, ST_IGNORED, '0));
    rows.push_back(mk(ACT_ADD, '1, '0, 1, ST_IGNORED, '0));
    rows.push_back(mk(ACT_ADD, '0, '0, 1, ST_OK, '0));
    rows.push_back(mk(ACT_PICK, '0, '0, 1, ST_NOTBUILT, '0));
    rows.push_back(mk(ACT_BUILD, '0, '0, 1, ST_OK, '0));
    rows.push_back(mk(ACT_PICK, '0, '1, 1, ST_NOTBUILT, '0));
    rows.push_back(mk(ACT_CLEAR, '1, '1, 1, ST_OK, '0));
    rows.push_back(mk(ACT_BUILD, '0, '0, 1, ST_OK, '0));
    rows.push_back(mk(ACT_PICK, '1, '1, 1, ST_OK, '0));
    foreach (rows[i]) begin
      it.action = rows[i].act; it.entry_value = rows[i].val; it.random_draw = rows[i].draw;
      send_item(it, rows[i].fixed, rows[i].res);
    end

    write_range(31'd8);
    for (int unsigned i = 0; i < 6; i++) send_op(ACT_ADD, 30'(i * 2), '0);
    send_op(ACT_ADD, 30'd2, '0);
    send_op(ACT_BUILD, '0, '0);
    for (int unsigned i = 0; i < 4; i++) send_op(ACT_PICK, '0, 31'($urandom));
    send_op(ACT_ADD, 30'd7, '0);
    send_op(ACT_ADD, 30'd1, '0);
    send_op(ACT_BUILD, '0, '0);
    send_op(ACT_PICK, '0, '1);
    write_range(31'd4);
    send_op(ACT_BUILD, '0, '0);
    send_op(ACT_PICK, '0, 31'd5);

    write_range('1);
    random_phase(250, RangeCap);
    write_range(31'd0);
    send_op(ACT_ADD, '0, '0);
    send_op(ACT_BUILD, '0, '0);
    send_op(ACT_PICK, '0, '1);
    write_range(31'd70);
    random_phase(300, 31'd70);
    write_range(31'd16);
    random_phase(250, 31'd16);
    write_range(31'd1);
    random_phase(60, 31'd1);
    write_range(31'd100000);
    random_phase(280, 31'd100000);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * MaxEntries + 16) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall != 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = gap_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_item);
        errors++;
      end else begin
        if (out_item.status !== pending_results[0].status) begin
          $display("%0t status: expected %0d actual %0d", $time,
                   pending_results[0].status, out_item.status);
          errors++;
        end
        if (out_item.result_value !== pending_results[0].result_value) begin
          $display("%0t result_value: expected %0d actual %0d", $time,
                   pending_results[0].result_value, out_item.result_value);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
